// ===== hdl/glyph_column_blit_1bpp_assert.svh =====
// Assertion macros for the glyph column blit block.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef GLYPH_COLUMN_BLIT_1BPP_ASSERT_SVH
`define GLYPH_COLUMN_BLIT_1BPP_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication.
`define GCB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("glyph blit check failed");
// Next-cycle implication.
`define GCB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("glyph blit check failed");
`else
`define GCB_ASSERT_NOW(lbl, ante, cons)
`define GCB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/gcb_pkg.sv =====
`timescale 1ns / 1ps

package gcb_pkg;

  localparam int NUM_COLUMNS      = 250;
  localparam int BYTES_PER_COLUMN = 16;
  localparam int STORE_BYTES      = NUM_COLUMNS * BYTES_PER_COLUMN;
  localparam int ADDR_W           = $clog2(STORE_BYTES);

  // Widest glyph and widest span of bytes one draw touches
  localparam int GLYPH_MAX_BYTES  = 4;
  localparam int SPAN_BYTES       = GLYPH_MAX_BYTES + 1;
  localparam int SPAN_IDX_W       = $clog2(SPAN_BYTES + 1);

  // Linear draw address: column * bytes + row byte + span offset
  localparam int SPAN_W = $clog2(256 * BYTES_PER_COLUMN + 16 + SPAN_BYTES + 1);

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_DRAW  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [7:0] WHITE_BYTE = 8'hFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  column_x;
    logic [6:0]  pixel_row;
    logic [31:0] glyph_bits;
    logic        tall_font;
    logic        no_invert;
    logic [11:0] read_address;
  } gcb_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       out_of_range;
  } gcb_out_t;

  typedef struct packed {
    logic [SPAN_BYTES-1:0][7:0] bytes;
    logic [7:0]                 keep_low;
  } gcb_align_t;

endpackage

// ===== hdl/gcb_glyph_align.sv =====
`timescale 1ns / 1ps

module gcb_glyph_align (
  input  logic [31:0]         glyph_bits,
  input  logic                tall_font,
  input  logic                no_invert,
  input  logic [2:0]          bit_shift,
  output gcb_pkg::gcb_align_t align
);
  import gcb_pkg::*;

  logic [SPAN_BYTES-1:0][7:0] glyph_b;
  logic [SPAN_BYTES*8-1:0]    col_w;
  logic [SPAN_BYTES*8-1:0]    shifted_w;
  logic [7:0]                 raw_b;

  always_comb begin
    // invert where asked; short glyphs drop the upper two bytes
    for (int j = 0; j < SPAN_BYTES; j++) begin
      if (j < GLYPH_MAX_BYTES) begin
        raw_b = glyph_bits[8*j +: 8];
      end else begin
        raw_b = 8'h00;
      end
      if ((j < 2 || tall_font) && j < GLYPH_MAX_BYTES) begin
        glyph_b[j] = no_invert ? raw_b : ~raw_b;
      end else begin
        glyph_b[j] = 8'h00;
      end
    end
    // byte 0 sits at the top (MSB end) of the column word
    for (int j = 0; j < SPAN_BYTES; j++) begin
      col_w[(SPAN_BYTES-1-j)*8 +: 8] = glyph_b[j];
    end
    shifted_w = col_w >> bit_shift;
    for (int j = 0; j < SPAN_BYTES; j++) begin
      align.bytes[j] = shifted_w[(SPAN_BYTES-1-j)*8 +: 8];
    end
    align.keep_low = WHITE_BYTE >> bit_shift;
  end

endmodule

// ===== hdl/glyph_column_blit_1bpp.sv =====
`timescale 1ns / 1ps
// Draw: two or four glyph bytes, plus one more when the row is not byte aligned; such a row
//   first passes the merge-read states RD_FIRST, RD_LAST and MERGE, then one write per byte.
// Read: states RD_BYTE and RD_CAP fetch the byte. Clear: all STORE_BYTES bytes, one byte written per cycle.
// Result: the DONE state moves the result into the output register; the output register
//   frees the sequencer so the next transaction is accepted
//   while a result waits.
// Reset: synchronous, active low; a white-fill sweep of all STORE_BYTES bytes follows reset,
//   during which no transaction is accepted.
module glyph_column_blit_1bpp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gcb_pkg::gcb_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output gcb_pkg::gcb_out_t out_data
);
  import gcb_pkg::*;

  // One-hot sequencer states
  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_CLEAR    = 9'b000000010,
    ST_RD_FIRST = 9'b000000100,
    ST_RD_LAST  = 9'b000001000,
    ST_MERGE    = 9'b000010000,
    ST_WRITE    = 9'b000100000,
    ST_RD_BYTE  = 9'b001000000,
    ST_RD_CAP   = 9'b010000000,
    ST_DONE     = 9'b100000000
  } state_t;

  // Frame store: one write port, one registered read port
  logic [7:0] frame_mem [STORE_BYTES];

  state_t                state_r, state_nxt;
  gcb_in_t               item_r, item_nxt;
  gcb_out_t              res_r, res_nxt;
  gcb_out_t              out_data_r;
  logic                  out_valid_r;
  logic [SPAN_W-1:0]     base_r, base_nxt;
  logic [SPAN_IDX_W-1:0] n_r, n_nxt;
  logic [SPAN_IDX_W-1:0] j_r, j_nxt;
  logic [ADDR_W-1:0]     clr_addr_r, clr_addr_nxt;
  logic                  clr_result_r, clr_result_nxt;
  logic [7:0]            old_first_r, old_first_nxt;
  logic [7:0]            old_last_r, old_last_nxt;
  logic [7:0]            rd_data_r;
  logic                  rd_ok_r;

  logic                  in_accept;
  logic                  draw_shift;
  logic                  out_load;
  logic [SPAN_W-1:0]     glyph_h;
  logic                  shift_on;
  logic                  rd_req;
  logic [SPAN_W-1:0]     rd_addr_wide;
  logic                  rd_in_range;
  logic                  mem_re;
  logic [SPAN_W-1:0]     wr_addr_wide;
  logic                  wr_in_range;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [7:0]            mem_wdata;
  logic [7:0]            merged_byte;
  logic [7:0]            rd_value;
  gcb_align_t            align;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Incoming draw whose row is not byte aligned needs the merge reads first
  assign draw_shift = (in_data.cmd == CMD_DRAW) && (in_data.pixel_row[2:0] != 3'd0);

  // Move the result into the output register once it is empty or being drained
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  assign glyph_h  = item_r.tall_font ? SPAN_W'(4) : SPAN_W'(2);
  assign shift_on = (item_r.pixel_row[2:0] != 3'd0);
  assign rd_value = rd_ok_r ? rd_data_r : 8'h00;

  gcb_glyph_align u_align (
    .glyph_bits (item_r.glyph_bits),
    .tall_font  (item_r.tall_font),
    .no_invert  (item_r.no_invert),
    .bit_shift  (item_r.pixel_row[2:0]),
    .align      (align)
  );

  // Read port: first merge byte, last merge byte, or the requested read byte
  always_comb begin
    rd_req       = 1'b0;
    rd_addr_wide = base_r;
    case (state_r)
      ST_RD_FIRST: begin
        rd_req       = 1'b1;
        rd_addr_wide = base_r;
      end
      ST_RD_LAST: begin
        rd_req       = 1'b1;
        rd_addr_wide = base_r + glyph_h;
      end
      ST_RD_BYTE: begin
        rd_req       = 1'b1;
        rd_addr_wide = SPAN_W'(item_r.read_address);
      end
      default: begin
        rd_req = 1'b0;
      end
    endcase
  end

  assign rd_in_range = (rd_addr_wide < SPAN_W'(STORE_BYTES));
  assign mem_re      = rd_req && rd_in_range;

  // Merge the kept bits of the partial end bytes into the aligned glyph byte
  always_comb begin
    merged_byte = align.bytes[j_r];
    if (shift_on && j_r == '0) begin
      merged_byte = merged_byte | (old_first_r & ~align.keep_low);
    end
    if (shift_on && SPAN_W'(j_r) == glyph_h) begin
      merged_byte = merged_byte | (old_last_r & align.keep_low);
    end
  end

  // Write port: white fill during a sweep, glyph bytes during a draw
  assign wr_addr_wide = (state_r == ST_CLEAR) ? SPAN_W'(clr_addr_r) : base_r + SPAN_W'(j_r);
  assign wr_in_range  = (wr_addr_wide < SPAN_W'(STORE_BYTES));
  assign mem_we       = (state_r == ST_CLEAR) || ((state_r == ST_WRITE) && wr_in_range);
  assign mem_waddr    = wr_addr_wide[ADDR_W-1:0];
  assign mem_wdata    = (state_r == ST_CLEAR) ? WHITE_BYTE : merged_byte;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= frame_mem[rd_addr_wide[ADDR_W-1:0]];
    end
    if (rd_req) begin
      rd_ok_r <= rd_in_range;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    res_nxt        = res_r;
    base_nxt       = base_r;
    n_nxt          = n_r;
    j_nxt          = j_r;
    clr_addr_nxt   = clr_addr_r;
    clr_result_nxt = clr_result_r;
    old_first_nxt  = old_first_r;
    old_last_nxt   = old_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          item_nxt = in_data;
          res_nxt  = '0;
          base_nxt = SPAN_W'(in_data.column_x) * SPAN_W'(BYTES_PER_COLUMN)
                     + SPAN_W'(in_data.pixel_row[6:3]);
          n_nxt    = SPAN_IDX_W'(in_data.tall_font ? 4 : 2)
                     + SPAN_IDX_W'(in_data.pixel_row[2:0] != 3'd0);
          j_nxt    = '0;
          case (in_data.cmd)
            CMD_CLEAR: begin
              clr_addr_nxt   = '0;
              clr_result_nxt = 1'b1;
              state_nxt      = ST_CLEAR;
            end
            CMD_DRAW: begin
              state_nxt = draw_shift ? ST_RD_FIRST : ST_WRITE;
            end
            CMD_READ: begin
              state_nxt = ST_RD_BYTE;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_W'(STORE_BYTES - 1)) begin
          clr_result_nxt = 1'b0;
          state_nxt      = clr_result_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_RD_FIRST: begin
        state_nxt = ST_RD_LAST;
      end
      ST_RD_LAST: begin
        old_first_nxt = rd_value;
        state_nxt     = ST_MERGE;
      end
      ST_MERGE: begin
        old_last_nxt = rd_value;
        state_nxt    = ST_WRITE;
      end
      ST_WRITE: begin
        // drop bytes beyond the store and flag them
        if (!wr_in_range) begin
          res_nxt.out_of_range = 1'b1;
        end
        j_nxt = j_r + 1'b1;
        if (j_r == n_r - 1'b1) begin
          state_nxt = ST_DONE;
        end
      end
      ST_RD_BYTE: begin
        state_nxt = ST_RD_CAP;
      end
      ST_RD_CAP: begin
        res_nxt.read_data = rd_value;
        state_nxt         = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      clr_result_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      clr_result_r <= clr_result_nxt;
      out_valid_r  <= out_load || (out_valid_r && out_stall);
    end
  end

  // Payload registers: hold between updates, no reset
  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    res_r       <= res_nxt;
    base_r      <= base_nxt;
    n_r         <= n_nxt;
    j_r         <= j_nxt;
    old_first_r <= old_first_nxt;
    old_last_r  <= old_last_nxt;
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  // Checks
  `include "glyph_column_blit_1bpp_assert.svh"

  `GCB_ASSERT_NOW(a_write_in_store, mem_we, wr_addr_wide < SPAN_W'(STORE_BYTES))
  `GCB_ASSERT_NOW(a_write_states, mem_we, state_r == ST_CLEAR || state_r == ST_WRITE)
  `GCB_ASSERT_NOW(a_write_count, state_r == ST_WRITE, j_r < n_r)
  `GCB_ASSERT_NEXT(a_merge_first, in_accept && draw_shift, state_r == ST_RD_FIRST)

endmodule
